// ----- sv/mts_pkg.sv -----
package mts_pkg;

    localparam int STACK_DEPTH_DEFAULT = 256;
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 9;
    localparam int ERR_W   = 2;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic [ERR_W-1:0]         error;
        logic                     is_empty;
        logic [DEPTH_W-1:0]       depth;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] top_value;
    } result_t;

endpackage

// ----- sv/mts_ram.sv -----
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mts_core.sv -----
module mts_core #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_cmd,
    input  logic signed [mts_pkg::DATA_W-1:0] in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mts_pkg::result_t                  out_result,
    output logic                              ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]    ram_addr,
    output logic [mts_pkg::DATA_W-1:0]        ram_wr_value,
    output logic [mts_pkg::DATA_W-1:0]        ram_wr_min,
    input  logic [mts_pkg::DATA_W-1:0]        ram_rd_value,
    input  logic [mts_pkg::DATA_W-1:0]        ram_rd_min
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic signed [mts_pkg::DATA_W-1:0] top_reg, top_next;
    logic signed [mts_pkg::DATA_W-1:0] min_reg, min_next;
    logic                              out_valid_reg, out_valid_next;
    mts_pkg::result_t                  out_reg, out_next;

    logic          in_fire;
    logic          is_empty;
    logic          is_full;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          produce;
    logic [mts_pkg::ERR_W-1:0] err;

    function automatic mts_pkg::result_t make_result(
        input logic [CW-1:0]                     cnt,
        input logic signed [mts_pkg::DATA_W-1:0] top,
        input logic signed [mts_pkg::DATA_W-1:0] mn,
        input logic [mts_pkg::ERR_W-1:0]         e
    );
        mts_pkg::result_t r;
        r.error = e;
        if (cnt == '0) begin
            r.top_value = mts_pkg::EMPTY_WORD;
            r.min_value = mts_pkg::EMPTY_WORD;
            r.depth     = '0;
            r.is_empty  = 1'b1;
        end else begin
            r.top_value = top;
            r.min_value = mn;
            r.depth     = mts_pkg::DEPTH_W'(cnt);
            r.is_empty  = 1'b0;
        end
        return r;
    endfunction

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // the top entry lives in registers, entries below it in the RAM
    assign ram_wr_value = top_reg;
    assign ram_wr_min   = min_reg;
    assign ram_addr     = ram_we ? cnt_m1[AW-1:0] : cnt_m2[AW-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        min_next   = min_reg;
        ram_we     = 1'b0;
        produce    = 1'b0;
        err        = mts_pkg::ERR_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_cmd == mts_pkg::CMD_PUSH) begin
                        if (is_full) begin
                            err     = mts_pkg::ERR_PUSH_FULL;
                            produce = 1'b1;
                        end else begin
                            ram_we     = !is_empty;
                            top_next   = in_value;
                            min_next   = (is_empty || in_value < min_reg) ? in_value : min_reg;
                            count_next = count_reg + CW'(1);
                            produce    = 1'b1;
                        end
                    end else begin
                        if (is_empty) begin
                            err     = mts_pkg::ERR_POP_EMPTY;
                            produce = 1'b1;
                        end else if (count_reg == CW'(1)) begin
                            count_next = '0;
                            produce    = 1'b1;
                        end else begin
                            // new top comes from the RAM next cycle
                            count_next = cnt_m1;
                            state_next = ST_POP_WAIT;
                        end
                    end
                end
            end
            ST_POP_WAIT: begin
                top_next   = ram_rd_value;
                min_next   = ram_rd_min;
                produce    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (produce) begin
            out_valid_next = 1'b1;
            out_next       = make_result(count_next, top_next, min_next, err);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        top_reg <= top_next;
        min_reg <= min_next;
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_pop_wait_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP_WAIT |-> $past(in_fire && in_cmd == mts_pkg::CMD_POP))
        else $error("pop wait without an accepted pop");

    a_no_accept_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP_WAIT |-> !in_ready)
        else $error("request accepted during pop wait");

    a_ram_write_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> in_fire && in_cmd == mts_pkg::CMD_PUSH && !is_full && !is_empty)
        else $error("RAM write outside a push");

    a_empty_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.is_empty |-> out_reg.depth == '0)
        else $error("empty result with nonzero depth");

endmodule

// ----- sv/min_tracking_stack.sv -----
// Min-tracking stack: LIFO of signed 32-bit values that also reports the least value held.
// Push or failed request: result registered, m_tvalid rises in the cycle after acceptance;
// pushes can be taken every cycle unless m_tready stalls. A pop leaving entries reads the
// entry store, loads the new top in ST_POP_WAIT, then registers its result (top is in registers).
// Reset (aresetn low, synchronous): entry count and output valid cleared, stack empty.
// Entry stores are not cleared; only entries written by earlier pushes are ever read.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] cmd (0 push, 1 pop)
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] top_value, [63:32] min_value, [72:64] depth, zero pad
    output logic [2:0]  m_tuser    // [0] is_empty, [2:1] error
);

    localparam int AW = $clog2(STACK_DEPTH);

    mts_pkg::result_t              result;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [mts_pkg::DATA_W-1:0]    ram_wr_value;
    logic [mts_pkg::DATA_W-1:0]    ram_wr_min;
    logic [mts_pkg::DATA_W-1:0]    ram_rd_value;
    logic [mts_pkg::DATA_W-1:0]    ram_rd_min;

    // stack control: top entry registers, count, result register
    mts_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser[0]),
        .in_value     (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (result),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wr_value (ram_wr_value),
        .ram_wr_min   (ram_wr_min),
        .ram_rd_value (ram_rd_value),
        .ram_rd_min   (ram_rd_min)
    );

    // values below the top
    mts_ram #(
        .WIDTH(mts_pkg::DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wr_value),
        .rdata (ram_rd_value)
    );

    // running minimum from the bottom up to each level
    mts_ram #(
        .WIDTH(mts_pkg::DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_min_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wr_min),
        .rdata (ram_rd_min)
    );

    assign m_tdata = {7'd0, result.depth, result.min_value, result.top_value};
    assign m_tuser = {result.error, result.is_empty};

endmodule
